FILE: hw/rtl/periodic_cell_neighbour_generator_assert.svh
// Assertion helpers for the RTL of the neighbour generator.
`ifndef PERIODIC_CELL_NEIGHBOUR_GENERATOR_ASSERT_SVH
`define PERIODIC_CELL_NEIGHBOUR_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PCNG_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PCNG_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pcng_pkg.sv
package pcng_pkg;

  localparam int IDX_W           = 18;
  localparam int SLOT_W          = 5;
  localparam int CFG_W           = 7;
  localparam int DATA_W          = 32;
  localparam int ADDR_W          = 4;
  localparam int NEIGHBOUR_COUNT = 26;
  localparam int RING_SIZE       = 8;
  localparam int AXIAL_FIRST     = 24;

  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NEIGHBOUR_COUNT - 1);
  localparam logic [CFG_W-1:0]  SIDE_RESET = CFG_W'(4);

  typedef enum logic [1:0] {
    REG_CELLS_X = 2'd0,
    REG_CELLS_Y = 2'd1,
    REG_CELLS_Z = 2'd2
  } cfg_reg_t;

  // Which of the three wrapped coordinates along an axis a slot uses.
  typedef enum logic [1:0] {
    SEL_SAME  = 2'd0,
    SEL_PLUS  = 2'd1,
    SEL_MINUS = 2'd2
  } sel_t;

  typedef struct packed {
    sel_t plane_sel;
    sel_t row_sel;
    sel_t col_sel;
  } slot_sel_t;

  // Everything the emitter needs to form the 26 neighbour indices of a cell.
  typedef struct packed {
    logic [2:0][IDX_W-1:0] plane_base;
    logic [2:0][IDX_W-1:0] row_base;
    logic [2:0][IDX_W-1:0] col;
    logic                  bad;
  } front_item_t;

  function automatic slot_sel_t slot_lookup(input logic [SLOT_W-1:0] s);
    slot_sel_t r;
    r.plane_sel = SEL_SAME;
    r.row_sel   = SEL_SAME;
    r.col_sel   = SEL_SAME;
    if (int'(s) < RING_SIZE) begin
      r.plane_sel = SEL_SAME;
    end else if (int'(s) < 2 * RING_SIZE) begin
      r.plane_sel = SEL_PLUS;
    end else if (int'(s) < AXIAL_FIRST) begin
      r.plane_sel = SEL_MINUS;
    end else if (int'(s) == AXIAL_FIRST) begin
      r.plane_sel = SEL_PLUS;
    end else begin
      r.plane_sel = SEL_MINUS;
    end
    if (int'(s) < AXIAL_FIRST) begin
      // Ring order: the next row, the same row, then the previous row;
      // columns run left to right and the centre is skipped.
      case (s[2:0])
        3'd0: begin r.row_sel = SEL_PLUS;  r.col_sel = SEL_MINUS; end
        3'd1: begin r.row_sel = SEL_PLUS;  r.col_sel = SEL_SAME;  end
        3'd2: begin r.row_sel = SEL_PLUS;  r.col_sel = SEL_PLUS;  end
        3'd3: begin r.row_sel = SEL_SAME;  r.col_sel = SEL_MINUS; end
        3'd4: begin r.row_sel = SEL_SAME;  r.col_sel = SEL_PLUS;  end
        3'd5: begin r.row_sel = SEL_MINUS; r.col_sel = SEL_MINUS; end
        3'd6: begin r.row_sel = SEL_MINUS; r.col_sel = SEL_SAME;  end
        default: begin r.row_sel = SEL_MINUS; r.col_sel = SEL_PLUS; end
      endcase
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/pcng_front.sv
module pcng_front import pcng_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [IDX_W-1:0]        cell_idx,
  input  logic [$clog2(MAX_SIDE+1)-1:0]   sx,
  input  logic [$clog2(MAX_SIDE+1)-1:0]   sy,
  input  logic [$clog2(MAX_SIDE+1)-1:0]   sz,
  input  logic [2*$clog2(MAX_SIDE+1)-1:0] plane,
  input  logic [3*$clog2(MAX_SIDE+1)-1:0] total,
  output logic                    out_valid,
  input  logic                    out_stall,
  output front_item_t             out_item
);

  localparam int SW  = $clog2(MAX_SIDE + 1);
  localparam int DW  = (3 * SW > IDX_W) ? 3 * SW : IDX_W;
  localparam int DS  = 2 * SW;
  localparam int WS  = DS + 1;
  localparam int MS  = DS + 2;
  localparam int NS  = DS + 3;
  localparam int PPW = 3 * SW;
  localparam int RPW = 2 * SW;

  logic          v   [0:NS-1];
  logic          rdy [0:NS];
  logic [DW-1:0] rem [0:DS];
  logic [SW-1:0] quo1 [1:DS];
  logic [SW-1:0] quo2 [SW+1:DS];
  logic          bad [1:DS];

  assign rdy[NS]   = !out_stall;
  assign in_stall  = !rdy[0];
  assign out_valid = v[MS];

  for (genvar i = 0; i < NS; i++) begin : g_ctl
    assign rdy[i] = !v[i] || rdy[i+1];
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          v[i] <= 1'b0;
        end else if (rdy[i]) begin
          v[i] <= in_valid;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          v[i] <= 1'b0;
        end else if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rem[0] <= DW'(cell_idx);
    end
  end

  // Restoring division, one quotient bit per stage: first by the plane size
  // to get the plane number, then by the row length to get the row.
  for (genvar i = 1; i <= DS; i++) begin : g_div
    logic [DW-1:0] dsh;
    logic          take;
    logic          bad_nx;

    assign take = rem[i-1] >= dsh;

    if (i == 1) begin : g_bad_first
      assign bad_nx = rem[0] >= DW'(total);
    end else begin : g_bad_pass
      assign bad_nx = bad[i-1];
    end

    if (i <= SW) begin : g_plane
      logic [SW-1:0] qprev;
      assign dsh = DW'(plane) << (SW - i);
      if (i == 1) begin : g_q0
        assign qprev = '0;
      end else begin : g_qn
        assign qprev = quo1[i-1];
      end
      always_ff @(posedge clk) begin
        if (rdy[i]) begin
          rem[i]  <= take ? rem[i-1] - dsh : rem[i-1];
          quo1[i] <= (qprev << 1) | SW'(take);
          bad[i]  <= bad_nx;
        end
      end
    end else begin : g_row
      logic [SW-1:0] qprev;
      assign dsh = DW'(sx) << (DS - i);
      if (i == SW + 1) begin : g_q0
        assign qprev = '0;
      end else begin : g_qn
        assign qprev = quo2[i-1];
      end
      always_ff @(posedge clk) begin
        if (rdy[i]) begin
          rem[i]  <= take ? rem[i-1] - dsh : rem[i-1];
          quo1[i] <= quo1[i-1];
          quo2[i] <= (qprev << 1) | SW'(take);
          bad[i]  <= bad_nx;
        end
      end
    end
  end

  function automatic logic [SW-1:0] wrap_up(input logic [SW-1:0] x, input logic [SW-1:0] n);
    logic [SW:0] s;
    s = {1'b0, x} + 1'b1;
    return (s == {1'b0, n}) ? '0 : s[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] wrap_dn(input logic [SW-1:0] x, input logic [SW-1:0] n);
    return (x == '0) ? n - 1'b1 : x - 1'b1;
  endfunction

  logic [2:0][SW-1:0] pl_w;
  logic [2:0][SW-1:0] rw_w;
  logic [2:0][SW-1:0] cl_w;
  logic               bad_w;
  logic [SW-1:0]      p_d;
  logic [SW-1:0]      r_d;
  logic [SW-1:0]      q_d;

  assign p_d = quo1[DS];
  assign r_d = quo2[DS];
  assign q_d = rem[DS][SW-1:0];

  always_ff @(posedge clk) begin
    if (rdy[WS]) begin
      pl_w[SEL_SAME]  <= p_d;
      pl_w[SEL_PLUS]  <= wrap_up(p_d, sz);
      pl_w[SEL_MINUS] <= wrap_dn(p_d, sz);
      rw_w[SEL_SAME]  <= r_d;
      rw_w[SEL_PLUS]  <= wrap_up(r_d, sy);
      rw_w[SEL_MINUS] <= wrap_dn(r_d, sy);
      cl_w[SEL_SAME]  <= q_d;
      cl_w[SEL_PLUS]  <= wrap_up(q_d, sx);
      cl_w[SEL_MINUS] <= wrap_dn(q_d, sx);
      bad_w           <= bad[DS];
    end
  end

  logic [2:0][PPW-1:0] pprod;
  logic [2:0][RPW-1:0] rprod;
  front_item_t         item_next;

  always_comb begin
    item_next.bad = bad_w;
    for (int j = 0; j < 3; j++) begin
      pprod[j] = PPW'(pl_w[j]) * PPW'(plane);
      rprod[j] = RPW'(rw_w[j]) * RPW'(sx);
      item_next.plane_base[j] = IDX_W'(pprod[j]);
      item_next.row_base[j]   = IDX_W'(rprod[j]);
      item_next.col[j]        = IDX_W'(cl_w[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[MS]) begin
      out_item <= item_next;
    end
  end

endmodule

FILE: hw/rtl/periodic_cell_neighbour_generator.sv
// Channel     Direction  Handshake                    Payload
// cell        in         cell_valid / cell_stall      cell_index
// neighbour   out        neighbour_valid / neighbour_stall
//                                                     neighbour_index, slot, last, bad_cell
// config      in         APB (psel, penable, pready)  paddr, pwdata, prdata
//
// Each cell item yields 26 neighbour items, one per cycle from the output
// register while the output does not stall; the next cell is taken in the
// same cycle that the last slot of the one before leaves. The cell passes
// a division pipeline, a wrap stage and a multiply stage before the emitter.
// Reset is synchronous and active high; the cell channel is stalled after
// reset and after every register write while the grid sizes settle.
// A stall on the output holds the result in place and backs up the pipeline.

`include "periodic_cell_neighbour_generator_assert.svh"

module periodic_cell_neighbour_generator import pcng_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cell_valid,
  output logic                cell_stall,
  input  logic [IDX_W-1:0]    cell_index,
  output logic                neighbour_valid,
  input  logic                neighbour_stall,
  output logic [IDX_W-1:0]    neighbour_index,
  output logic [SLOT_W-1:0]   slot,
  output logic                last,
  output logic                bad_cell,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam int SW  = $clog2(MAX_SIDE + 1);
  localparam int PLW = 2 * SW;
  localparam int TW  = 3 * SW;

  // ---------------------------------------------------------------------
  // Configuration registers. The raw written bits are kept and read back;
  // the grid logic works on the clamped sides below.
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] cells_x;
  logic [CFG_W-1:0] cells_y;
  logic [CFG_W-1:0] cells_z;
  logic             cfg_wr;
  logic             cfg_settle;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x <= SIDE_RESET;
      cells_y <= SIDE_RESET;
      cells_z <= SIDE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[ADDR_W-1:2])
        REG_CELLS_X: cells_x <= pwdata[CFG_W-1:0];
        REG_CELLS_Y: cells_y <= pwdata[CFG_W-1:0];
        REG_CELLS_Z: cells_z <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_CELLS_X: prdata = DATA_W'(cells_x);
      REG_CELLS_Y: prdata = DATA_W'(cells_y);
      REG_CELLS_Z: prdata = DATA_W'(cells_z);
      default:     prdata = '0;
    endcase
  end

  // The plane size and cell count are registered one after the other, so
  // the cell channel waits in the cycle after a write before taking an item.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_settle <= 1'b1;
    end else begin
      cfg_settle <= cfg_wr;
    end
  end

  // A side of zero counts as one and a side beyond the maximum is clamped.
  function automatic logic [SW-1:0] eff_side(input logic [CFG_W-1:0] x);
    logic [SW-1:0] e;
    if (x == '0) begin
      e = SW'(1);
    end else if (int'(x) > MAX_SIDE) begin
      e = SW'(MAX_SIDE);
    end else begin
      e = SW'(x);
    end
    return e;
  endfunction

  logic [SW-1:0]  side_x;
  logic [SW-1:0]  side_y;
  logic [SW-1:0]  side_z;
  logic [PLW-1:0] plane_cells;
  logic [TW-1:0]  total_cells;

  assign side_x = eff_side(cells_x);
  assign side_y = eff_side(cells_y);
  assign side_z = eff_side(cells_z);

  always_ff @(posedge clk) begin
    plane_cells <= PLW'(side_x) * PLW'(side_y);
    total_cells <= TW'(plane_cells) * TW'(side_z);
  end

  // ---------------------------------------------------------------------
  // Front pipeline: splits the cell into plane, row and column, wraps each
  // coordinate both ways and forms the partial index bases.
  // ---------------------------------------------------------------------
  logic        front_in_stall;
  logic        front_valid;
  logic        front_stall;
  front_item_t front_item;

  assign cell_stall = front_in_stall || cfg_settle;

  pcng_front #(
    .MAX_SIDE(MAX_SIDE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cell_valid && !cfg_settle),
    .in_stall (front_in_stall),
    .cell_idx (cell_index),
    .sx       (side_x),
    .sy       (side_y),
    .sz       (side_z),
    .plane    (plane_cells),
    .total    (total_cells),
    .out_valid(front_valid),
    .out_stall(front_stall),
    .out_item (front_item)
  );

  // ---------------------------------------------------------------------
  // Emitter: walks the 26 slots of the held cell, one per cycle unless the
  // output stalls, adding the plane base, row base and column picked by the
  // slot table; the next cell loads in the same cycle the last slot leaves.
  // ---------------------------------------------------------------------
  front_item_t       item;
  logic              busy;
  logic [SLOT_W-1:0] slot_cnt;
  logic              out_ld;
  logic              fire;
  logic              at_last;
  logic              front_take;
  slot_sel_t         sel;
  logic [IDX_W-1:0]  idx_next;

  assign out_ld      = !neighbour_valid || !neighbour_stall;
  assign fire        = busy && out_ld;
  assign at_last     = slot_cnt == LAST_SLOT;
  assign front_stall = busy && !(out_ld && at_last);
  assign front_take  = front_valid && !front_stall;
  assign sel         = slot_lookup(slot_cnt);

  always_comb begin
    idx_next = item.plane_base[sel.plane_sel] + item.row_base[sel.row_sel]
             + item.col[sel.col_sel];
    if (item.bad) begin
      idx_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      slot_cnt        <= '0;
      neighbour_valid <= 1'b0;
    end else begin
      if (front_take) begin
        busy     <= 1'b1;
        slot_cnt <= '0;
      end else if (fire) begin
        busy     <= !at_last;
        slot_cnt <= slot_cnt + 1'b1;
      end
      if (out_ld) begin
        neighbour_valid <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (front_take) begin
      item <= front_item;
    end
    if (fire) begin
      neighbour_index <= idx_next;
      slot            <= slot_cnt;
      last            <= at_last;
      bad_cell        <= item.bad;
    end
  end

  // Within one cell the slots count up by one with nothing skipped.
  `PCNG_ASSERT_NXT(a_slot_step, clk, rst, neighbour_valid && !neighbour_stall && !last, neighbour_valid && slot == $past(slot) + 5'd1, "neighbour slot did not advance by one")
  // The out-of-grid flag belongs to the cell and cannot change mid-run.
  `PCNG_ASSERT_NXT(a_bad_steady, clk, rst, neighbour_valid && !neighbour_stall && !last, bad_cell == $past(bad_cell), "bad_cell changed within one cell")
  // A run that follows a finished one starts again at slot zero.
  `PCNG_ASSERT_IMP(a_run_start, clk, rst, neighbour_valid && $past(neighbour_valid && !neighbour_stall && last), slot == 5'd0, "new cell did not start at slot zero")
  // No cell is taken while the derived grid sizes are still settling.
  `PCNG_ASSERT_NXT(a_cfg_hold, clk, rst, cfg_wr, cell_stall, "cell accepted right after a register write")

endmodule
